// File: rtl/ufwr_pkg.sv
// Shared types, register offsets and command codes of the UART FIFO register block.
package ufwr_pkg;

	// Default number of entries in each byte FIFO.
	localparam int DEFAULT_FIFO_DEPTH = 8;

	// Widths of the beat fields.
	localparam int CMD_W    = 2;
	localparam int OFFSET_W = 5;
	localparam int WORD_W   = 32;
	localparam int BYTE_W   = 8;
	localparam int THRESH_W = 16;

	// Command codes carried in the slave-side tuser.
	typedef enum logic [CMD_W-1:0] {
		CMD_BUS_READ  = 2'd0,
		CMD_BUS_WRITE = 2'd1,
		CMD_LINE_RX   = 2'd2,
		CMD_LINE_TX   = 2'd3
	} command_t;

	// Register byte offsets.
	localparam logic [OFFSET_W-1:0] OFF_TXDATA = 5'h00;
	localparam logic [OFFSET_W-1:0] OFF_RXDATA = 5'h04;
	localparam logic [OFFSET_W-1:0] OFF_TXCTRL = 5'h08;
	localparam logic [OFFSET_W-1:0] OFF_RXCTRL = 5'h0C;
	localparam logic [OFFSET_W-1:0] OFF_IE     = 5'h10;
	localparam logic [OFFSET_W-1:0] OFF_IP     = 5'h14;
	localparam logic [OFFSET_W-1:0] OFF_DIV    = 5'h18;

	// Status flag in bit 31 of txdata and rxdata reads.
	localparam logic [WORD_W-1:0] FLAG_31 = 32'h8000_0000;

	// Watermark bit positions in ip and ie.
	localparam int WM_TX_BIT = 0;
	localparam int WM_RX_BIT = 1;

	// Result fields settled when the beat is accepted; FIFO bytes join from the registered memory read data.
	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic              use_rx_mem;
		logic              use_tx_mem;
		logic              tx_valid;
		logic              rx_accepted;
		logic              bad_offset;
		logic              irq;
	} ufwr_stage_t;

endpackage

// File: rtl/ufwr_fifo_ram.sv
// Byte-wide synchronous memory with one write port and one registered read port.
module ufwr_fifo_ram
	import ufwr_pkg::*;
#(
	parameter int DEPTH = DEFAULT_FIFO_DEPTH,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next enabled read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/ufwr_regs.sv
// Register decode, FIFO pointers and counters, and watermark interrupt logic.
module ufwr_regs
	import ufwr_pkg::*;
#(
	parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH,
	parameter int AW         = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [CMD_W-1:0]    command,
	input  logic [OFFSET_W-1:0] reg_offset,
	input  logic [WORD_W-1:0]   bus_wdata,
	input  logic [BYTE_W-1:0]   line_byte,
	output logic                tx_wr_en,
	output logic [AW-1:0]       tx_wr_addr,
	output logic [BYTE_W-1:0]   tx_wr_data,
	output logic                tx_rd_en,
	output logic [AW-1:0]       tx_rd_addr,
	output logic                rx_wr_en,
	output logic [AW-1:0]       rx_wr_addr,
	output logic [BYTE_W-1:0]   rx_wr_data,
	output logic                rx_rd_en,
	output logic [AW-1:0]       rx_rd_addr,
	output ufwr_stage_t         stage
);

	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [CW-1:0] FULL_COUNT = CW'(FIFO_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT  = AW'(FIFO_DEPTH - 1);
	localparam logic [SW-1:0] DEPTH_SUM  = SW'(FIFO_DEPTH);

	logic [AW-1:0]     tx_head_q, rx_head_q;
	logic [CW-1:0]     tx_count_q, rx_count_q;
	logic [WORD_W-1:0] tx_control_q, rx_control_q, irq_enable_q, baud_divisor_q;

	logic [CW-1:0]     tx_count_d, rx_count_d;
	logic [AW-1:0]     tx_head_d, rx_head_d;
	logic [WORD_W-1:0] tx_control_d, rx_control_d, irq_enable_d, baud_divisor_d;
	logic              tx_full, rx_full;
	logic              push_tx, pop_tx, push_rx, pop_rx;
	logic              tx_wm_now, rx_wm_now, tx_wm_next, rx_wm_next;
	logic [SW-1:0]     tx_tail_sum, rx_tail_sum;
	logic [WORD_W-1:0] rdata;
	logic              bad;

	assign tx_full = (tx_count_q == FULL_COUNT);
	assign rx_full = (rx_count_q == FULL_COUNT);

	// Watermark conditions on the current state, as seen by an ip read.
	assign tx_wm_now = (THRESH_W'(tx_count_q) < tx_control_q[WORD_W-1 -: THRESH_W]);
	assign rx_wm_now = (THRESH_W'(rx_count_q) > rx_control_q[WORD_W-1 -: THRESH_W]);

	// Command and register decode.
	always_comb begin
		rdata          = '0;
		bad            = 1'b0;
		push_tx        = 1'b0;
		pop_tx         = 1'b0;
		push_rx        = 1'b0;
		pop_rx         = 1'b0;
		tx_control_d   = tx_control_q;
		rx_control_d   = rx_control_q;
		irq_enable_d   = irq_enable_q;
		baud_divisor_d = baud_divisor_q;
		case (command)
			CMD_BUS_READ: begin
				case (reg_offset)
					OFF_TXDATA: rdata = tx_full ? FLAG_31 : '0;
					OFF_RXDATA: begin
						if (rx_count_q == '0) begin
							rdata = FLAG_31;
						end else begin
							pop_rx = 1'b1;
						end
					end
					OFF_TXCTRL: rdata = tx_control_q;
					OFF_RXCTRL: rdata = rx_control_q;
					OFF_IE:     rdata = irq_enable_q;
					OFF_IP: begin
						rdata[WM_TX_BIT] = tx_wm_now;
						rdata[WM_RX_BIT] = rx_wm_now;
					end
					OFF_DIV:    rdata = baud_divisor_q;
					default:    bad = 1'b1;
				endcase
			end
			CMD_BUS_WRITE: begin
				case (reg_offset)
					OFF_TXDATA: push_tx = !tx_full;
					OFF_RXDATA: ;
					OFF_TXCTRL: tx_control_d = bus_wdata;
					OFF_RXCTRL: rx_control_d = bus_wdata;
					OFF_IE:     irq_enable_d = bus_wdata;
					OFF_IP:     ;
					OFF_DIV:    baud_divisor_d = bus_wdata;
					default:    bad = 1'b1;
				endcase
			end
			CMD_LINE_RX: push_rx = !rx_full;
			CMD_LINE_TX: pop_tx = (tx_count_q != '0);
			default: ;
		endcase
	end

	// Tail slot is head plus count, folded back once into the ring.
	always_comb begin
		tx_tail_sum = SW'(tx_head_q) + SW'(tx_count_q);
		if (tx_tail_sum >= DEPTH_SUM) begin
			tx_tail_sum = tx_tail_sum - DEPTH_SUM;
		end
		rx_tail_sum = SW'(rx_head_q) + SW'(rx_count_q);
		if (rx_tail_sum >= DEPTH_SUM) begin
			rx_tail_sum = rx_tail_sum - DEPTH_SUM;
		end
	end

	// Next pointers and counts; at most one FIFO operation per beat.
	always_comb begin
		tx_head_d  = tx_head_q;
		rx_head_d  = rx_head_q;
		tx_count_d = tx_count_q;
		rx_count_d = rx_count_q;
		if (push_tx) begin
			tx_count_d = tx_count_q + CW'(1);
		end
		if (pop_tx) begin
			tx_count_d = tx_count_q - CW'(1);
			tx_head_d  = (tx_head_q == LAST_SLOT) ? '0 : tx_head_q + AW'(1);
		end
		if (push_rx) begin
			rx_count_d = rx_count_q + CW'(1);
		end
		if (pop_rx) begin
			rx_count_d = rx_count_q - CW'(1);
			rx_head_d  = (rx_head_q == LAST_SLOT) ? '0 : rx_head_q + AW'(1);
		end
	end

	// Interrupt level after this beat takes effect.
	assign tx_wm_next = (THRESH_W'(tx_count_d) < tx_control_d[WORD_W-1 -: THRESH_W]);
	assign rx_wm_next = (THRESH_W'(rx_count_d) > rx_control_d[WORD_W-1 -: THRESH_W]);

	// Memory requests.
	assign tx_wr_en   = accept && push_tx;
	assign tx_wr_addr = tx_tail_sum[AW-1:0];
	assign tx_wr_data = bus_wdata[BYTE_W-1:0];
	assign tx_rd_en   = accept && pop_tx;
	assign tx_rd_addr = tx_head_q;
	assign rx_wr_en   = accept && push_rx;
	assign rx_wr_addr = rx_tail_sum[AW-1:0];
	assign rx_wr_data = line_byte;
	assign rx_rd_en   = accept && pop_rx;
	assign rx_rd_addr = rx_head_q;

	// Result fields known at acceptance.
	always_comb begin
		stage.read_data   = rdata;
		stage.use_rx_mem  = pop_rx;
		stage.use_tx_mem  = pop_tx;
		stage.tx_valid    = pop_tx;
		stage.rx_accepted = push_rx;
		stage.bad_offset  = bad;
		stage.irq         = (irq_enable_d[WM_TX_BIT] && tx_wm_next) ||
		                    (irq_enable_d[WM_RX_BIT] && rx_wm_next);
	end

	// State update on each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_head_q      <= '0;
			rx_head_q      <= '0;
			tx_count_q     <= '0;
			rx_count_q     <= '0;
			tx_control_q   <= '0;
			rx_control_q   <= '0;
			irq_enable_q   <= '0;
			baud_divisor_q <= '0;
		end else if (accept) begin
			tx_head_q      <= tx_head_d;
			rx_head_q      <= rx_head_d;
			tx_count_q     <= tx_count_d;
			rx_count_q     <= rx_count_d;
			tx_control_q   <= tx_control_d;
			rx_control_q   <= rx_control_d;
			irq_enable_q   <= irq_enable_d;
			baud_divisor_q <= baud_divisor_d;
		end
	end

endmodule

// File: rtl/uart_fifo_watermark_registers_unit.sv
// Top level of the UART register block with transmit and receive byte FIFOs.
//
// Slave side: one beat is one event. s_tuser carries the command (bus read, bus
// write, line byte arrives, line takes a byte); s_tdata carries the register
// offset, the write word and the received line byte.
// Master side: exactly one result beat per input beat, in order: read word,
// transmitted byte with its valid flag, receive acceptance, bad offset flag and
// the irq level after the event.
// Throughput is one beat per cycle while the receiver does not stall. The result
// passes the stage 1 register and then the output register: the registers and
// counters update at acceptance while the FIFO byte memories are read, and the
// registered memory data is merged into the output register once it is free.
// Reset clears the counters, pointers and control registers; the FIFO memories
// are not cleared, as an entry is read only after it was written.
// When the receiver stalls, the output register holds its beat, one more beat
// waits in the stage behind it, and s_tready drops until the output drains.
module uart_fifo_watermark_registers_unit
	import ufwr_pkg::*;
#(
	parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // reg_offset[4:0], wdata[36:5], line_byte[44:37]
	input  logic [1:0]   s_tuser,   // command[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata    // read_data[31:0], tx_byte[39:32], tx_valid[40],
	                                // rx_accepted[41], bad_offset[42], irq[43]
);

	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	logic              accept;
	logic              out_free;
	logic              valid_s1;
	ufwr_stage_t       stage;
	ufwr_stage_t       stage_s1;
	logic              m_valid_q;
	logic [47:0]       m_data_q;
	logic [47:0]       out_word;

	logic              tx_wr_en, tx_rd_en, rx_wr_en, rx_rd_en;
	logic [AW-1:0]     tx_wr_addr, tx_rd_addr, rx_wr_addr, rx_rd_addr;
	logic [BYTE_W-1:0] tx_wr_data, rx_wr_data, tx_rd_data, rx_rd_data;
	logic [WORD_W-1:0] read_word;
	logic [BYTE_W-1:0] tx_byte;

	// Handshake: the stage takes a beat when empty or when it hands on its own.
	assign out_free = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	ufwr_regs #(
		.FIFO_DEPTH (FIFO_DEPTH),
		.AW         (AW)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (s_tuser[CMD_W-1:0]),
		.reg_offset (s_tdata[4:0]),
		.bus_wdata  (s_tdata[36:5]),
		.line_byte  (s_tdata[44:37]),
		.tx_wr_en   (tx_wr_en),
		.tx_wr_addr (tx_wr_addr),
		.tx_wr_data (tx_wr_data),
		.tx_rd_en   (tx_rd_en),
		.tx_rd_addr (tx_rd_addr),
		.rx_wr_en   (rx_wr_en),
		.rx_wr_addr (rx_wr_addr),
		.rx_wr_data (rx_wr_data),
		.rx_rd_en   (rx_rd_en),
		.rx_rd_addr (rx_rd_addr),
		.stage      (stage)
	);

	ufwr_fifo_ram #(
		.DEPTH (FIFO_DEPTH),
		.AW    (AW)
	) u_tx_ram (
		.clk     (clk),
		.wr_en   (tx_wr_en),
		.wr_addr (tx_wr_addr),
		.wr_data (tx_wr_data),
		.rd_en   (tx_rd_en),
		.rd_addr (tx_rd_addr),
		.rd_data (tx_rd_data)
	);

	ufwr_fifo_ram #(
		.DEPTH (FIFO_DEPTH),
		.AW    (AW)
	) u_rx_ram (
		.clk     (clk),
		.wr_en   (rx_wr_en),
		.wr_addr (rx_wr_addr),
		.wr_data (rx_wr_data),
		.rd_en   (rx_rd_en),
		.rd_addr (rx_rd_addr),
		.rd_data (rx_rd_data)
	);

	// Stage 1 valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Stage 1 payload, loaded on each accepted beat; the memory read data changes only together with it.
	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1 <= stage;
		end
	end

	// Merge the FIFO bytes into the result beat.
	assign read_word = stage_s1.use_rx_mem ? WORD_W'(rx_rd_data) : stage_s1.read_data;
	assign tx_byte   = stage_s1.use_tx_mem ? tx_rd_data : '0;
	assign out_word  = {4'b0000, stage_s1.irq, stage_s1.bad_offset, stage_s1.rx_accepted,
	                    stage_s1.tx_valid, tx_byte, read_word};

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			m_data_q <= out_word;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// File: tb/uart_fifo_watermark_registers_unit_tb.sv
// Self-checking testbench for the UART register block with transmit and receive byte FIFOs.
`timescale 1ns / 100ps

module uart_fifo_watermark_registers_unit_tb;
	import ufwr_pkg::*;

	localparam int DEPTH = DEFAULT_FIFO_DEPTH;
	localparam int PAW = $clog2(DEPTH);
	localparam int N_PHASES = 4;
	localparam int ITEMS_PER_PHASE = 480;
	localparam int TILT_SPAN = 40;
	localparam int DRAIN_CYCLES = 8;

	// One result beat, unpacked from m_tdata.
	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic [BYTE_W-1:0] tx_byte;
		logic              tx_valid;
		logic              rx_accepted;
		logic              bad_offset;
		logic              irq;
	} uart_result_t;

	// One row of the directed table. A row with has_want set carries its own expected result.
	typedef struct packed {
		command_t          cmd;
		logic [OFFSET_W-1:0] off;
		logic [WORD_W-1:0] wdata;
		logic [BYTE_W-1:0] lbyte;
		logic [3:0]        reps;
		logic              has_want;
		uart_result_t      want;
	} stim_row_t;

	localparam uart_result_t ALL_ZERO = '0;
	localparam uart_result_t RX_EMPTY = '{FLAG_31, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
	localparam uart_result_t BAD_REG  = '{32'h0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0};

	localparam int N_DIRECTED = 28;

	// Directed stimulus: extremes, every register, both FIFOs through full and empty.
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{CMD_BUS_READ,  OFF_TXDATA, 32'h0000_0000, 8'h00, 4'd1, 1'b1, ALL_ZERO},
		'{CMD_BUS_READ,  OFF_RXDATA, 32'hFFFF_FFFF, 8'hFF, 4'd1, 1'b1, RX_EMPTY},
		'{CMD_LINE_TX,   OFF_TXDATA, 32'h0000_0000, 8'h00, 4'd1, 1'b1, ALL_ZERO},
		'{CMD_BUS_READ,  5'h01,      32'h0000_0000, 8'h00, 4'd1, 1'b1, BAD_REG},
		'{CMD_BUS_WRITE, 5'h1F,      32'hFFFF_FFFF, 8'h00, 4'd1, 1'b1, BAD_REG},
		'{CMD_BUS_READ,  5'h1C,      32'h0000_0000, 8'h00, 4'd1, 1'b1, BAD_REG},
		'{CMD_BUS_READ,  OFF_IP,     32'h0000_0000, 8'h00, 4'd1, 1'b1, ALL_ZERO},
		'{CMD_BUS_WRITE, OFF_IE,     32'hFFFF_FFFF, 8'h00, 4'd1, 1'b0, ALL_ZERO},
		'{CMD_BUS_WRITE, OFF_TXCTRL, 32'hFFFF_0000, 8'h00, 4'd1, 1'b0, ALL_ZERO},
		'{CMD_BUS_WRITE, OFF_RXCTRL, 32'h0000_FFFF, 8'h00, 4'd1, 1'b0, ALL_ZERO},
		'{CMD_BUS_WRITE, OFF_DIV,    32'hFFFF_FFFF, 8'h00, 4'd1, 1'b0, ALL_ZERO},
		'{CMD_BUS_READ,  OFF_TXCTRL, 32'h0000_0000, 8'h00, 4'd1, 1'b0, ALL_ZERO},
		'{CMD_BUS_READ,  OFF_RXCTRL, 32'h0000_0000, 8'h00, 4'd1, 1'b0, ALL_ZERO},
		'{CMD_BUS_READ,  OFF_IE,     32'h0000_0000, 8'h00, 4'd1, 1'b0, ALL_ZERO},
		'{CMD_BUS_READ,  OFF_DIV,    32'h0000_0000, 8'h00, 4'd1, 1'b0, ALL_ZERO},
		'{CMD_BUS_READ,  OFF_IP,     32'h0000_0000, 8'h00, 4'd1, 1'b0, ALL_ZERO},
		'{CMD_BUS_WRITE, OFF_RXDATA, 32'hFFFF_FFFF, 8'h00, 4'd1, 1'b0, ALL_ZERO},
		'{CMD_BUS_WRITE, OFF_IP,     32'hFFFF_FFFF, 8'h00, 4'd1, 1'b0, ALL_ZERO},
		'{CMD_BUS_WRITE, OFF_TXDATA, 32'hFFFF_FFFF, 8'h00, 4'd5, 1'b0, ALL_ZERO},
		'{CMD_BUS_WRITE, OFF_TXDATA, 32'h0000_0000, 8'h00, 4'd4, 1'b0, ALL_ZERO},
		'{CMD_BUS_READ,  OFF_TXDATA, 32'h0000_0000, 8'h00, 4'd1, 1'b0, ALL_ZERO},
		'{CMD_LINE_RX,   OFF_TXDATA, 32'h0000_0000, 8'hFF, 4'd5, 1'b0, ALL_ZERO},
		'{CMD_LINE_RX,   OFF_TXDATA, 32'h0000_0000, 8'h00, 4'd4, 1'b0, ALL_ZERO},
		'{CMD_LINE_TX,   OFF_TXDATA, 32'h0000_0000, 8'h00, 4'd9, 1'b0, ALL_ZERO},
		'{CMD_BUS_READ,  OFF_RXDATA, 32'h0000_0000, 8'h00, 4'd9, 1'b0, ALL_ZERO},
		'{CMD_BUS_WRITE, OFF_TXCTRL, 32'h0000_0000, 8'h00, 4'd1, 1'b0, ALL_ZERO},
		'{CMD_BUS_WRITE, OFF_RXCTRL, 32'hFFFF_FFFF, 8'h00, 4'd1, 1'b0, ALL_ZERO},
		'{CMD_BUS_WRITE, OFF_IE,     32'h0000_0000, 8'h00, 4'd1, 1'b0, ALL_ZERO}
	};

	localparam logic [OFFSET_W-1:0] REG_OFFSETS [7] = '{
		OFF_TXDATA, OFF_RXDATA, OFF_TXCTRL, OFF_RXCTRL, OFF_IE, OFF_IP, OFF_DIV
	};

	// Idle percentages of the sender and the receiver per phase.
	localparam int SEND_IDLE [N_PHASES] = '{0, 78, 0, 24};
	localparam int RECV_STALL [N_PHASES] = '{0, 0, 78, 24};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;

	// Predictor state: the two byte FIFOs and the control registers.
	logic [BYTE_W-1:0] tx_fifo [DEPTH];
	logic [BYTE_W-1:0] rx_fifo [DEPTH];
	int                tx_rd;
	int                tx_level;
	int                rx_rd;
	int                rx_level;
	logic [WORD_W-1:0] txctrl_q;
	logic [WORD_W-1:0] rxctrl_q;
	logic [WORD_W-1:0] ie_q;
	logic [WORD_W-1:0] div_q;

	uart_result_t pending_results [$];
	int           error_count;
	int           send_idle_pct;
	int           stall_pct;

	uart_fifo_watermark_registers_unit #(
		.FIFO_DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Hard limit on the run time.
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watermark bits as seen in ip.
	function automatic logic [1:0] watermark_bits();
		logic [1:0] wm;
		wm = '0;
		wm[WM_TX_BIT] = (tx_level < int'(txctrl_q[31:THRESH_W]));
		wm[WM_RX_BIT] = (rx_level > int'(rxctrl_q[31:THRESH_W]));
		return wm;
	endfunction

	// Applies one event to the predictor state and returns the result beat it causes.
	function automatic uart_result_t uart_event_result(command_t cmd, logic [OFFSET_W-1:0] off,
			logic [WORD_W-1:0] wdata, logic [BYTE_W-1:0] lbyte);
		uart_result_t res;
		res = '0;
		case (cmd)
			CMD_BUS_READ: begin
				case (off)
					OFF_TXDATA: res.read_data = (tx_level >= DEPTH) ? FLAG_31 : '0;
					OFF_RXDATA: begin
						if (rx_level == 0) begin
							res.read_data = FLAG_31;
						end else begin
							res.read_data = {24'h0, rx_fifo[PAW'(rx_rd)]};
							rx_rd = (rx_rd + 1) % DEPTH;
							rx_level--;
						end
					end
					OFF_TXCTRL: res.read_data = txctrl_q;
					OFF_RXCTRL: res.read_data = rxctrl_q;
					OFF_IE:     res.read_data = ie_q;
					OFF_IP:     res.read_data = {30'h0, watermark_bits()};
					OFF_DIV:    res.read_data = div_q;
					default:    res.bad_offset = 1'b1;
				endcase
			end
			CMD_BUS_WRITE: begin
				case (off)
					OFF_TXDATA: begin
						if (tx_level < DEPTH) begin
							tx_fifo[PAW'((tx_rd + tx_level) % DEPTH)] = wdata[BYTE_W-1:0];
							tx_level++;
						end
					end
					OFF_RXDATA, OFF_IP: ;
					OFF_TXCTRL: txctrl_q = wdata;
					OFF_RXCTRL: rxctrl_q = wdata;
					OFF_IE:     ie_q = wdata;
					OFF_DIV:    div_q = wdata;
					default:    res.bad_offset = 1'b1;
				endcase
			end
			CMD_LINE_RX: begin
				if (rx_level < DEPTH) begin
					rx_fifo[PAW'((rx_rd + rx_level) % DEPTH)] = lbyte;
					rx_level++;
					res.rx_accepted = 1'b1;
				end
			end
			default: begin
				if (tx_level != 0) begin
					res.tx_byte = tx_fifo[PAW'(tx_rd)];
					res.tx_valid = 1'b1;
					tx_rd = (tx_rd + 1) % DEPTH;
					tx_level--;
				end
			end
		endcase
		res.irq = |(watermark_bits() & ie_q[1:0]);
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
		$display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	// Offers one beat, with a random gap before it, and records its expected result at acceptance.
	task automatic send_beat(command_t cmd, logic [OFFSET_W-1:0] off, logic [WORD_W-1:0] wdata,
			logic [BYTE_W-1:0] lbyte, logic has_want, uart_result_t want);
		uart_result_t res;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {3'b000, lbyte, wdata, off};
		do
			@(posedge clk);
		while (!s_tready);
		res = uart_event_result(cmd, off, wdata, lbyte);
		pending_results.push_back(has_want ? want : res);
	endtask

	// Random event. While filling, pushes into the FIFOs outweigh pops, and the reverse otherwise.
	task automatic send_random_beat(bit filling);
		int                  r;
		command_t            cmd;
		logic [OFFSET_W-1:0] off;
		logic [WORD_W-1:0]   wdata;
		logic [BYTE_W-1:0]   lbyte;
		wdata = $urandom;
		lbyte = BYTE_W'($urandom_range(255));
		off = ($urandom_range(9) < 8) ? REG_OFFSETS[3'($urandom_range(6))]
		                              : OFFSET_W'($urandom_range(31));
		r = $urandom_range(99);
		if (r < 12) begin
			cmd = CMD_BUS_READ;
		end else if (r < 24) begin
			cmd = CMD_BUS_WRITE;
			// Small thresholds keep the watermarks within reach of the FIFO levels.
			if ((off == OFF_TXCTRL || off == OFF_RXCTRL) && $urandom_range(3) != 0)
				wdata[31:THRESH_W] = THRESH_W'($urandom_range(DEPTH + 1));
		end else begin
			if ($urandom_range(99) < (filling ? 70 : 30))
				cmd = $urandom_range(1) ? CMD_LINE_RX : CMD_BUS_WRITE;
			else
				cmd = $urandom_range(1) ? CMD_LINE_TX : CMD_BUS_READ;
			if (cmd == CMD_BUS_WRITE)
				off = OFF_TXDATA;
			else if (cmd == CMD_BUS_READ)
				off = OFF_RXDATA;
		end
		send_beat(cmd, off, wdata, lbyte, 1'b0, ALL_ZERO);
	endtask

	// Holds the sender off until every expected result has come back.
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// Receiver: random stalls, and each accepted result beat is checked against the oldest expectation.
	always @(posedge clk) begin
		uart_result_t got;
		uart_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[39:32], m_tdata[40], m_tdata[41], m_tdata[42],
			       m_tdata[43]};
			if (pending_results.size() == 0) begin
				$display("%0t ns: result beat 0x%0h with nothing expected", $time, m_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.read_data !== want.read_data)
					report_mismatch("read_data", got.read_data, want.read_data);
				if (got.tx_byte !== want.tx_byte)
					report_mismatch("tx_byte", WORD_W'(got.tx_byte), WORD_W'(want.tx_byte));
				if (got.tx_valid !== want.tx_valid)
					report_mismatch("tx_valid", WORD_W'(got.tx_valid), WORD_W'(want.tx_valid));
				if (got.rx_accepted !== want.rx_accepted)
					report_mismatch("rx_accepted", WORD_W'(got.rx_accepted),
						WORD_W'(want.rx_accepted));
				if (got.bad_offset !== want.bad_offset)
					report_mismatch("bad_offset", WORD_W'(got.bad_offset),
						WORD_W'(want.bad_offset));
				if (got.irq !== want.irq)
					report_mismatch("irq", WORD_W'(got.irq), WORD_W'(want.irq));
			end
		end
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Main sequence: reset, directed table, then random phases with different idling.
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_BUS_READ;
		error_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		tx_rd = 0;
		tx_level = 0;
		rx_rd = 0;
		rx_level = 0;
		txctrl_q = '0;
		rxctrl_q = '0;
		ie_q = '0;
		div_q = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tx_fifo[PAW'(i)] = '0;
			rx_fifo[PAW'(i)] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			for (int n = 0; n < directed_rows[i].reps; n++)
				send_beat(directed_rows[i].cmd, directed_rows[i].off, directed_rows[i].wdata,
					directed_rows[i].lbyte, directed_rows[i].has_want, directed_rows[i].want);
		end
		wait_for_drain();

		for (int p = 0; p < N_PHASES; p++) begin
			send_idle_pct = SEND_IDLE[p];
			stall_pct = RECV_STALL[p];
			for (int k = 0; k < ITEMS_PER_PHASE; k++)
				send_random_beat(((k / TILT_SPAN) % 2) == 0);
			wait_for_drain();
		end

		stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: files.f
rtl/ufwr_pkg.sv
rtl/ufwr_fifo_ram.sv
rtl/ufwr_regs.sv
rtl/uart_fifo_watermark_registers_unit.sv
tb/uart_fifo_watermark_registers_unit_tb.sv
